>>> rtl/ftlp_pkg.sv
// Package with types and constants for the login-frame parser.
package ftlp_pkg;

    typedef enum logic [5:0] {
        PH_HDR  = 6'b000001,
        PH_VER  = 6'b000010,
        PH_FNAC = 6'b000100,
        PH_TLVH = 6'b001000,
        PH_VAL  = 6'b010000,
        PH_SKIP = 6'b100000
    } phase_t;

    localparam logic [2:0] EV_CHAR   = 3'd0;
    localparam logic [2:0] EV_ACCEPT = 3'd1;
    localparam logic [2:0] EV_REJECT = 3'd2;
    localparam logic [2:0] EV_VER    = 3'd3;
    localparam logic [2:0] EV_BAIL   = 3'd4;
    localparam logic [2:0] EV_DONE   = 3'd5;

    localparam logic [7:0]  START_MARK = 8'h2a;
    localparam logic [15:0] FAM_LOGIN  = 16'h0017;
    localparam logic [15:0] SUB_LOGIN  = 16'h0006;
    localparam logic [15:0] TLV_USER   = 16'h0001;
    localparam logic [15:0] TLV_VER    = 16'h0003;
    localparam logic [15:0] TLV_MAJOR  = 16'h0017;
    localparam logic [15:0] TLV_MINOR  = 16'h0018;
    localparam logic [15:0] TLV_LESSER = 16'h0019;

    typedef struct packed {
        logic [2:0]  ev;
        logic [7:0]  ch;
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] c;
    } res_t;

    typedef struct packed {
        logic [2:0] cnt;
        res_t       r0;
        res_t       r1;
        res_t       r2;
        res_t       r3;
    } res_set_t;

    function automatic logic name_char(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5a) ||
               (c >= 8'h61 && c <= 8'h7a) || c == 8'h2e || c == 8'h40 ||
               c == 8'h2d || c == 8'h5f;
    endfunction

endpackage

>>> rtl/ftlp_step.sv
// Parser state and per-byte next-state and result logic.
module ftlp_step import ftlp_pkg::*; #(
    parameter int USER_MAX = 255
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step,
    input  logic [7:0] data_byte,
    input  logic       first_of_segment,
    input  logic [15:0] segment_length,
    input  logic       from_initiator,
    output res_set_t   res
);
    phase_t      phase_reg, phase_next;
    logic [15:0] seg_reg, seg_next, frame_reg, frame_next, field_reg, field_next;
    logic [3:0]  pos_reg, pos_next;
    logic [2:0]  chan_reg, chan_next;
    logic [31:0] shift_reg, shift_next;
    logic [15:0] type_reg, type_next;
    logic        login_reg, login_next, uval_reg, uval_next, sawv_reg, sawv_next;
    logic [7:0]  ucnt_reg, ucnt_next;
    logic [15:0] maj_reg, maj_next, min_reg, min_next, les_reg, les_next;

    always_comb begin
        phase_t      ph;
        logic [15:0] seg, fl, tl;
        logic [31:0] sh;
        logic [15:0] part;
        logic        bail, fdone, tdone;
        res_t        e [4];
        logic [2:0]  n;
        ph = phase_reg; seg = seg_reg; fl = frame_reg; tl = 16'd0; sh = 32'd0;
        part = 16'd0;
        phase_next = phase_reg; seg_next = seg_reg; frame_next = frame_reg;
        field_next = field_reg; pos_next = pos_reg; chan_next = chan_reg;
        shift_next = shift_reg; type_next = type_reg; login_next = login_reg;
        uval_next = uval_reg; sawv_next = sawv_reg; ucnt_next = ucnt_reg;
        maj_next = maj_reg; min_next = min_reg; les_next = les_reg;
        bail = 1'b0; fdone = 1'b0; tdone = 1'b0; n = 3'd0;
        for (int i = 0; i < 4; i++) e[i] = '0;
        if (first_of_segment) begin
            ph = from_initiator ? PH_HDR : PH_SKIP;
            seg = (segment_length == 16'd0) ? 16'd1 : segment_length;
            fl = 16'd0; field_next = 16'd0; pos_next = 4'd0; chan_next = 3'd0;
            shift_next = 32'd0; type_next = 16'd0; login_next = 1'b0;
            uval_next = 1'b0; ucnt_next = 8'd0; sawv_next = 1'b0;
            maj_next = 16'd0; min_next = 16'd0; les_next = 16'd0;
        end
        phase_next = ph;
        if (seg != 16'd0) begin
            seg = seg - 16'd1;
            frame_next = fl;
            if (ph != PH_HDR && ph != PH_SKIP && fl != 16'd0) frame_next = fl - 16'd1;
            case (ph)
                PH_HDR: begin
                    if (pos_next == 4'd0) begin
                        if (data_byte != START_MARK) bail = 1'b1;
                        else pos_next = 4'd1;
                    end else if (pos_next == 4'd1) begin
                        if (data_byte < 8'd1 || data_byte > 8'd5) bail = 1'b1;
                        else begin
                            chan_next = data_byte[2:0];
                            shift_next = 32'd0;
                            pos_next = 4'd2;
                        end
                    end else begin
                        sh = {shift_next[23:0], data_byte};
                        shift_next = sh;
                        pos_next = pos_next + 4'd1;
                        if (pos_next >= 4'd6) begin
                            if (sh[15:0] > seg) bail = 1'b1;
                            else begin
                                frame_next = sh[15:0];
                                pos_next = 4'd0; shift_next = 32'd0;
                                sawv_next = 1'b0; login_next = 1'b0;
                                maj_next = 16'd0; min_next = 16'd0; les_next = 16'd0;
                                if (chan_next == 3'd1) begin
                                    if (sh[15:0] < 16'd4) bail = 1'b1;
                                    else phase_next = PH_VER;
                                end else if (chan_next == 3'd2) begin
                                    if (sh[15:0] < 16'd10) bail = 1'b1;
                                    else phase_next = PH_FNAC;
                                end else begin
                                    phase_next = PH_TLVH;
                                    if (sh[15:0] == 16'd0) fdone = 1'b1;
                                end
                            end
                        end
                    end
                end
                PH_VER: begin
                    if (data_byte != ((pos_reg == 4'd3) ? 8'd1 : 8'd0)) bail = 1'b1;
                    else begin
                        pos_next = pos_reg + 4'd1;
                        if (pos_next >= 4'd4) begin
                            phase_next = PH_TLVH; pos_next = 4'd0; shift_next = 32'd0;
                            if (frame_next == 16'd0) fdone = 1'b1;
                        end
                    end
                end
                PH_FNAC: begin
                    if (pos_reg < 4'd4) shift_next = {shift_reg[23:0], data_byte};
                    pos_next = pos_reg + 4'd1;
                    if (pos_next == 4'd4)
                        login_next = (shift_next[31:16] == FAM_LOGIN) &&
                                     (shift_next[15:0] == SUB_LOGIN);
                    if (pos_next >= 4'd10) begin
                        phase_next = PH_TLVH; pos_next = 4'd0; shift_next = 32'd0;
                        if (frame_next == 16'd0) fdone = 1'b1;
                    end
                end
                PH_TLVH: begin
                    sh = {shift_reg[23:0], data_byte};
                    shift_next = sh;
                    pos_next = pos_reg + 4'd1;
                    if (pos_next >= 4'd4) begin
                        type_next = sh[31:16];
                        field_next = sh[15:0];
                        if (sh[15:0] > frame_next) bail = 1'b1;
                        else begin
                            uval_next = 1'b1; ucnt_next = 8'd0;
                            if (sh[31:16] == TLV_VER || sh[31:16] == TLV_MAJOR ||
                                sh[31:16] == TLV_MINOR || sh[31:16] == TLV_LESSER)
                                sawv_next = 1'b1;
                            if (sh[31:16] == TLV_MAJOR) maj_next = 16'd0;
                            if (sh[31:16] == TLV_MINOR) min_next = 16'd0;
                            if (sh[31:16] == TLV_LESSER) les_next = 16'd0;
                            pos_next = 4'd0;
                            phase_next = PH_VAL;
                            if (sh[15:0] == 16'd0) tdone = 1'b1;
                        end
                    end else if (frame_next == 16'd0) bail = 1'b1;
                end
                PH_VAL: begin
                    part = (pos_reg == 4'd0) ? {data_byte, 8'd0} : {8'd0, data_byte};
                    tl = (field_reg != 16'd0) ? field_reg - 16'd1 : 16'd0;
                    field_next = tl;
                    if (type_reg == TLV_USER && login_reg) begin
                        if (!name_char(data_byte)) uval_next = 1'b0;
                        else if (uval_reg && ucnt_reg < 8'(USER_MAX)) begin
                            e[n[1:0]] = '{ev: EV_CHAR, ch: data_byte, default: '0};
                            n = n + 3'd1;
                            ucnt_next = ucnt_reg + 8'd1;
                        end
                    end
                    if (pos_reg < 4'd2) begin
                        if (type_reg == TLV_MAJOR) maj_next = maj_reg | part;
                        if (type_reg == TLV_MINOR) min_next = min_reg | part;
                        if (type_reg == TLV_LESSER) les_next = les_reg | part;
                        pos_next = pos_reg + 4'd1;
                    end
                    if (tl == 16'd0) tdone = 1'b1;
                end
                default: ;
            endcase
            if (bail) begin
                e[n[1:0]] = '{ev: EV_BAIL, default: '0}; n = n + 3'd1;
                phase_next = PH_SKIP;
            end
            if (tdone) begin
                if (type_next == TLV_USER && login_next) begin
                    e[n[1:0]] = '{ev: (uval_next ? EV_ACCEPT : EV_REJECT), default: '0};
                    n = n + 3'd1;
                end
                phase_next = PH_TLVH; pos_next = 4'd0; shift_next = 32'd0;
                if (frame_next == 16'd0) fdone = 1'b1;
            end
            if (fdone) begin
                if (sawv_next) begin
                    e[n[1:0]] = '{ev: EV_VER, ch: 8'd0, a: maj_next, b: min_next,
                                  c: les_next};
                    n = n + 3'd1;
                end
                phase_next = PH_HDR; pos_next = 4'd0; shift_next = 32'd0;
                sawv_next = 1'b0; login_next = 1'b0;
                maj_next = 16'd0; min_next = 16'd0; les_next = 16'd0;
            end
            if (seg == 16'd0 && phase_next != PH_SKIP) begin
                if (phase_next == PH_HDR && pos_next == 4'd0)
                    e[n[1:0]] = '{ev: EV_DONE, default: '0};
                else
                    e[n[1:0]] = '{ev: EV_BAIL, default: '0};
                n = n + 3'd1;
                phase_next = PH_SKIP;
            end
        end
        seg_next = seg;
        res = '{cnt: n, r0: e[0], r1: e[1], r2: e[2], r3: e[3]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HDR; seg_reg <= '0; frame_reg <= '0; field_reg <= '0;
            pos_reg <= '0; chan_reg <= '0; shift_reg <= '0; type_reg <= '0;
            login_reg <= 1'b0; uval_reg <= 1'b0; ucnt_reg <= '0; sawv_reg <= 1'b0;
            maj_reg <= '0; min_reg <= '0; les_reg <= '0;
        end else if (step) begin
            phase_reg <= phase_next; seg_reg <= seg_next; frame_reg <= frame_next;
            field_reg <= field_next; pos_reg <= pos_next; chan_reg <= chan_next;
            shift_reg <= shift_next; type_reg <= type_next; login_reg <= login_next;
            uval_reg <= uval_next; ucnt_reg <= ucnt_next; sawv_reg <= sawv_next;
            maj_reg <= maj_next; min_reg <= min_next; les_reg <= les_next;
        end
    end
endmodule

>>> rtl/ftlp_outq.sv
// Result register holding up to four results of one byte, drained one a cycle while m_ready is high.
module ftlp_outq import ftlp_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     load,
    input  res_set_t res,
    output logic     will_free,
    input  logic     m_ready,
    output logic     m_valid,
    output res_t     head,
    output logic     m_last
);
    res_t       q_reg [4];
    logic [2:0] cnt_reg, idx_reg;

    assign m_valid   = cnt_reg != idx_reg;
    assign head      = q_reg[idx_reg[1:0]];
    assign m_last    = (idx_reg + 3'd1) == cnt_reg;
    assign will_free = !m_valid || (m_ready && m_last);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            idx_reg <= '0;
        end else if (load) begin
            cnt_reg <= res.cnt;
            idx_reg <= '0;
        end else if (m_valid && m_ready) begin
            idx_reg <= idx_reg + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            q_reg[0] <= res.r0;
            q_reg[1] <= res.r1;
            q_reg[2] <= res.r2;
            q_reg[3] <= res.r3;
        end
    end
endmodule

>>> rtl/flap_tlv_login_parser_core.sv
// Top level of the login-frame parser.
// Results of a byte are registered and appear in the cycle after it is accepted.
// Throughput: one byte per cycle while m_ready is high and each byte gives at most one
// result; a byte with more results stalls the input while the result register drains.
// Reset: synchronous active-low aresetn; parser waits for a frame header,
// no segment open, result register empty.
module flap_tlv_login_parser_core import ftlp_pkg::*; #(
    parameter int USER_MAX = 255
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_first_of_segment,
    input  logic [15:0] s_segment_length,
    input  logic        s_from_initiator,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_event_res,
    output logic [7:0]  m_user_char,
    output logic [15:0] m_ver_major,
    output logic [15:0] m_ver_minor,
    output logic [15:0] m_ver_lesser,
    output logic        m_last
);
    res_set_t res;
    res_t     head;
    logic     will_free, step;

    assign s_ready = will_free;
    assign step    = s_valid && s_ready;

    ftlp_step #(.USER_MAX(USER_MAX)) u_step (
        .aclk, .aresetn, .step,
        .data_byte(s_data_byte), .first_of_segment(s_first_of_segment),
        .segment_length(s_segment_length), .from_initiator(s_from_initiator),
        .res
    );

    ftlp_outq u_outq (
        .aclk, .aresetn, .load(step && res.cnt != 3'd0), .res,
        .will_free, .m_ready, .m_valid, .head, .m_last
    );

    assign m_event_res  = head.ev;
    assign m_user_char  = head.ch;
    assign m_ver_major  = head.a;
    assign m_ver_minor  = head.b;
    assign m_ver_lesser = head.c;
endmodule

>>> rtl/ftlp_checker.sv
// Port-level checker for the parser, bound to the top level.
module ftlp_checker import ftlp_pkg::*; (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [2:0] m_event_res,
    input logic       m_last
);
    a_evt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_event_res <= EV_DONE) else $error("event code out of range");
    a_bail_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_event_res == EV_BAIL |-> m_last) else $error("bail not last");
    a_done_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_event_res == EV_DONE |-> m_last) else $error("done not last");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid) else $error("result dropped");
    a_rdy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last |-> !s_ready) else $error("request taken mid-burst");
endmodule

bind flap_tlv_login_parser_core ftlp_checker u_chk (
    .aclk, .aresetn, .s_ready, .m_valid, .m_ready, .m_event_res, .m_last
);
